### rtl/csd_pkg.sv
// ============================================================================
// csd_pkg
// Shared types and constants for the connection snapshot diff block.
// ============================================================================
`default_nettype none
package csd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MAX_RESULTS = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [1:0] CMD_ROW   = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] KIND_CREATED = 2'd0;
  localparam logic [1:0] KIND_CLOSED  = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  // First member sits in the highest bits, so the last one listed lands at bit 0.
  typedef struct packed {
    logic [15:0] remote_port;
    logic [31:0] remote_address;
    logic [15:0] local_port;
    logic [31:0] local_address;
    logic [31:0] process_id;
    logic [7:0]  protocol;
  } ident_t;

  localparam int IDENT_W = $bits(ident_t);

  typedef struct packed {
    logic [1:0] command;
    ident_t     ident;
  } qent_t;

  typedef struct packed {
    logic       found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  function automatic pick_t first_set(input logic [TABLE_DEPTH-1:0] vec);
    pick_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.found = 1'b1;
        res.idx   = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/csd_front.sv
// ============================================================================
// csd_front
// Accepts input transactions, drops unknown commands and pushes the rest.
// ============================================================================
`default_nettype none
module csd_front
  import csd_pkg::*;
(
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [IDENT_W-1:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire logic         q_full,
  output logic              q_push,
  output qent_t             q_wdata
);

  logic known;

  // Command code 3 has no effect, so it never takes a queue slot.
  always_comb begin
    case (in_tuser)
      CMD_ROW, CMD_END, CMD_CLEAR: known = 1'b1;
      default:                     known = 1'b0;
    endcase
  end

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full && known;
  assign q_wdata.command = in_tuser;
  assign q_wdata.ident   = ident_t'(in_tdata);

endmodule
`default_nettype wire

### rtl/csd_fifo.sv
// ============================================================================
// csd_fifo
// Short queue of classified commands between the front and the back end.
// ============================================================================
`default_nettype none
module csd_fifo
  import csd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  qent_t      wdata,
  output logic       full,
  input  wire logic  pop,
  output logic       rvalid,
  output qent_t      rdata
);

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_pop;

  assign full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rptr_r];
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/csd_back.sv
// ============================================================================
// csd_back
// Connection table, row lookup and end-of-snapshot sweep with output register.
// ============================================================================
`default_nettype none
module csd_back
  import csd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  qent_t      q_rdata,
  output logic       q_pop,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [IDENT_W-1:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_RES  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SEV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] prev_r;
  logic [TABLE_DEPTH-1:0] cur_r;
  logic [TABLE_DEPTH-1:0] match_r;
  logic                   seeded_r;
  ident_t                 cam_r [TABLE_DEPTH];
  ident_t                 ram_r [TABLE_DEPTH];
  ident_t                 rd_r;
  ident_t                 key_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   pend_valid_r;
  ident_t                 pend_r;

  logic                   out_valid_r;
  logic [1:0]             out_kind_r;
  ident_t                 out_id_r;
  logic                   out_last_r;

  logic                   out_free;
  logic                   emit;
  logic [1:0]             emit_kind;
  ident_t                 emit_id;
  logic                   emit_last;
  logic                   wr_en;
  pick_t                  hit;
  pick_t                  free;

  assign out_free = !out_valid_r || out_tready;
  assign hit      = first_set(match_r);
  assign free     = first_set(~valid_r);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_DONE;
    emit_id   = '0;
    emit_last = 1'b1;
    wr_en     = 1'b0;
    case (state_r)
      S_RES: begin
        if (!hit.found) begin
          if (!free.found) begin
            emit      = out_free;
            emit_kind = KIND_FULL;
            emit_id   = key_r;
          end else begin
            wr_en     = !seeded_r || out_free;
            emit      = seeded_r && out_free;
            emit_kind = KIND_CREATED;
            emit_id   = key_r;
          end
        end
      end
      S_SEV: begin
        // A held close goes out unmarked once a later one shows up.
        if (valid_r[idx_r] && !cur_r[idx_r] && prev_r[idx_r] &&
            (cnt_r < CNT_W'(MAX_RESULTS)) && pend_valid_r) begin
          emit      = out_free;
          emit_kind = KIND_CLOSED;
          emit_id   = pend_r;
          emit_last = 1'b0;
        end
      end
      S_FIN: begin
        emit = out_free;
        if (pend_valid_r) begin
          emit_kind = KIND_CLOSED;
          emit_id   = pend_r;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Tag compare lanes, one per entry.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_r[i] <= valid_r[i] && (cam_r[i] == key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cam_r[free.idx] <= key_r;
    end
  end

  // Identity copy that the sweep reads one entry at a time.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[free.idx] <= key_r;
    end
    rd_r <= ram_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r <= q_rdata.ident;
    end
    if (emit) begin
      out_kind_r <= emit_kind;
      out_id_r   <= emit_id;
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      prev_r       <= '0;
      cur_r        <= '0;
      seeded_r     <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[free.idx] <= 1'b1;
        prev_r[free.idx]  <= 1'b0;
        cur_r[free.idx]   <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            case (q_rdata.command)
              CMD_ROW: begin
                state_r <= S_CMP;
              end
              CMD_END: begin
                idx_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_SRD;
              end
              CMD_CLEAR: begin
                valid_r  <= '0;
                prev_r   <= '0;
                cur_r    <= '0;
                seeded_r <= 1'b0;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_CMP: begin
          state_r <= S_RES;
        end
        S_RES: begin
          if (hit.found) begin
            cur_r[hit.idx] <= 1'b1;
            state_r        <= S_IDLE;
          end else if (!free.found) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else if (wr_en) begin
            state_r <= S_IDLE;
          end
        end
        S_SRD: begin
          state_r <= S_SEV;
        end
        S_SEV: begin
          if (!valid_r[idx_r]) begin
            state_r <= (idx_r == IDX_W'(TABLE_DEPTH - 1)) ? S_FIN : S_SRD;
            idx_r   <= idx_r + 1'b1;
          end else if (cur_r[idx_r]) begin
            prev_r[idx_r] <= 1'b1;
            cur_r[idx_r]  <= 1'b0;
            state_r <= (idx_r == IDX_W'(TABLE_DEPTH - 1)) ? S_FIN : S_SRD;
            idx_r   <= idx_r + 1'b1;
          end else if (!(prev_r[idx_r] && (cnt_r < CNT_W'(MAX_RESULTS)) &&
                         pend_valid_r && !out_free)) begin
            if (prev_r[idx_r] && (cnt_r < CNT_W'(MAX_RESULTS))) begin
              pend_r       <= rd_r;
              pend_valid_r <= 1'b1;
              cnt_r        <= cnt_r + 1'b1;
            end
            valid_r[idx_r] <= 1'b0;
            prev_r[idx_r]  <= 1'b0;
            state_r <= (idx_r == IDX_W'(TABLE_DEPTH - 1)) ? S_FIN : S_SRD;
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            pend_valid_r <= 1'b0;
            seeded_r     <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### rtl/connection_snapshot_diff.sv
// ============================================================================
// connection_snapshot_diff
// Reports connections that appear and vanish between successive snapshots.
// ============================================================================
// Input transactions carry a command in in_tuser (row, end of snapshot, clear)
// and a connection identity in in_tdata. Rows are looked up in a 64-entry
// table; a new row yields CREATED once the first snapshot has ended, and a
// full table yields a dropped-row event. An end command sweeps the table in
// ascending order, reporting CLOSED for every vanished connection, with
// out_tlast on the final one, or a single DONE event when nothing closed.
// A two-entry queue separates the accepting front from the table engine, so
// in_tready stays high while the engine is busy until that queue fills.
// A row passes through the pop, tag compare, and resolve-and-write steps, and
// the next row is popped only once it has resolved; the resolve step loads any
// result into the output register, waiting while that register is held. An
// end command sweeps the table entry by entry: a read state fetches the entry
// from the identity memory and an evaluate state then judges it.
// When the receiver stalls, the output register holds its transaction and the
// engine waits at the next result; the queue then fills and in_tready drops.
// A synchronous reset (rst_n low) empties the table, the queue and the output.
// ============================================================================
`default_nettype none
module connection_snapshot_diff
  import csd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // protocol, process_id, local_address, local_port, remote_address, remote_port
  input  wire logic [135:0] in_tdata,
  // command
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // event_protocol, event_process_id, event_local_address, event_local_port,
  // event_remote_address, event_remote_port
  output logic [135:0]      out_tdata,
  // event_kind
  output logic [1:0]        out_tuser,
  // last_of_run
  output logic              out_tlast
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  qent_t q_wdata;
  qent_t q_rdata;

  csd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  csd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  csd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // A DONE event carries no identity and always ends its run.
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DONE) |-> (out_tlast && out_tdata == '0))
    else $error("DONE event with identity or without last mark");

  // Created and dropped-row events are single results.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_CREATED || out_tuser == KIND_FULL)) |-> out_tlast)
    else $error("single-result event without last mark");

  // After an unmarked CLOSED is taken, the run continues with another CLOSED.
  a_close_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == KIND_CLOSED && !out_tlast) ##1 out_tvalid
    |-> out_tuser == KIND_CLOSED)
    else $error("unterminated close run");
`endif

endmodule
`default_nettype wire

### tb/connection_snapshot_diff_test.sv
// ============================================================================
// connection_snapshot_diff_test
// Self-checking bench: drives connection rows, snapshot ends and clears, and
// compares every event against a behavioral table model of the block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module connection_snapshot_diff_test;
  import csd_pkg::*;

  localparam int RUN_LIMIT = 2000000;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One expected event.
  typedef struct packed {
    logic [1:0] kind;
    ident_t     ident;
    logic       last;
  } conn_event_t;

  // One stimulus row: command, identity, and optionally a typed-in expectation.
  typedef struct {
    logic [1:0]  command;
    ident_t      ident;
    bit          typed;
    conn_event_t typed_event;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  connection_snapshot_diff dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the connection table.
  bit     tbl_valid [TABLE_DEPTH];
  bit     tbl_prev  [TABLE_DEPTH];
  bit     tbl_cur   [TABLE_DEPTH];
  ident_t tbl_ident [TABLE_DEPTH];
  bit     tbl_seeded;

  conn_event_t pending_events[$];
  int          failures;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Identity packing in tdata: protocol lowest, remote port highest, which is
  // exactly the packed layout of ident_t.
  function automatic logic [135:0] pack_ident(ident_t id);
    return 136'(id);
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_prev[i]  = 1'b0;
      tbl_cur[i]   = 1'b0;
    end
    tbl_seeded = 1'b0;
  endfunction

  // Works out the events one transaction causes and queues them.
  function automatic void predict_events(logic [1:0] command, ident_t id);
    int          free_slot;
    int          closes;
    conn_event_t ev;
    free_slot = -1;
    closes = 0;
    ev = '0;
    case (command)
      CMD_ROW: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_ident[i] == id) begin
              tbl_cur[i] = 1'b1;
              return;
            end
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        ev.ident = id;
        ev.last  = 1'b1;
        if (free_slot < 0) begin
          ev.kind = KIND_FULL;
          pending_events.push_back(ev);
          return;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_prev[free_slot]  = 1'b0;
        tbl_cur[free_slot]   = 1'b1;
        tbl_ident[free_slot] = id;
        if (tbl_seeded) begin
          ev.kind = KIND_CREATED;
          pending_events.push_back(ev);
        end
      end
      CMD_END: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!tbl_valid[i]) continue;
          if (tbl_cur[i]) begin
            tbl_prev[i] = 1'b1;
            tbl_cur[i]  = 1'b0;
            continue;
          end
          if (tbl_prev[i] && closes < MAX_RESULTS) begin
            ev.kind  = KIND_CLOSED;
            ev.ident = tbl_ident[i];
            ev.last  = 1'b0;
            pending_events.push_back(ev);
            closes++;
          end
          tbl_valid[i] = 1'b0;
          tbl_prev[i]  = 1'b0;
        end
        tbl_seeded = 1'b1;
        if (closes == 0) begin
          ev = '0;
          ev.kind = KIND_DONE;
          ev.last = 1'b1;
          pending_events.push_back(ev);
        end else begin
          pending_events[$].last = 1'b1;
        end
      end
      CMD_CLEAR: table_clear();
      default: ;
    endcase
  endfunction

  // Sends one transaction, idling the sender at the current rate first.
  // in_tvalid stays high after the handshake, so the next call can follow
  // without a gap; an idle cycle or wait_drained drops it.
  task automatic send_item(logic [1:0] command, ident_t id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= command;
    in_tdata  <= pack_ident(id);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_events(command, id);
  endtask

  // Receiver: random stall, and a check of each accepted event against the
  // oldest expectation.
  always @(posedge clk) begin
    conn_event_t want;
    ident_t      got_id;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_tvalid && out_tready) begin
        got_id = ident_t'(out_tdata);
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event kind %0d ident %h", $time, out_tuser, got_id);
          failures++;
        end else begin
          want = pending_events.pop_front();
          if (want.kind !== out_tuser) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_tuser);
            failures++;
          end
          if (want.ident !== got_id) begin
            $display("%0t: identity expected %h actual %h", $time, want.ident, got_id);
            failures++;
          end
          if (want.last !== out_tlast) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_tlast);
            failures++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic ident_t random_ident();
    ident_t id;
    id.protocol       = 8'($urandom);
    id.process_id     = $urandom;
    id.local_address  = $urandom;
    id.local_port     = 16'($urandom);
    id.remote_address = $urandom;
    id.remote_port    = 16'($urandom);
    return id;
  endfunction

  // Identity drawn from a small pool, so rows repeat across snapshots.
  function automatic ident_t pool_ident(int n);
    ident_t id;
    id = '0;
    id.protocol       = 8'(6 + (n & 1) * 11);
    id.process_id     = 32'(1000 + n);
    id.local_address  = 32'hC0A8_0001 + n;
    id.local_port     = 16'(8000 + n);
    id.remote_address = 32'h0A00_0001 ^ (n << 8);
    id.remote_port    = 16'(443 + n);
    return id;
  endfunction

  // Stops sending and waits until every expected event has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0 && cycle_count < RUN_LIMIT) @(posedge clk);
  endtask

  stim_row_t directed[$];

  function automatic void add_row(logic [1:0] cmd, ident_t id, bit typed = 0,
                                  conn_event_t ev = '0);
    stim_row_t r;
    r.command     = cmd;
    r.ident       = id;
    r.typed       = typed;
    r.typed_event = ev;
    directed.push_back(r);
  endfunction

  initial begin
    ident_t      ones;
    conn_event_t done_ev;
    conn_event_t full_ev;
    int          live_pool;
    failures       = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_ROW;
    out_tready = 1'b1;
    table_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ones = '1;
    done_ev = '0;
    done_ev.kind = KIND_DONE;
    done_ev.last = 1'b1;

    // Directed: seeding with extremes, repeat, ignored command, end after seeding,
    // creation, vanishing, clear, and the ignored command code.
    add_row(CMD_END, '0, 1, done_ev);        // empty seeding snapshot
    add_row(CMD_CLEAR, '0);
    add_row(CMD_ROW, '0);                    // all-zero identity, seeding
    add_row(CMD_ROW, ones);                  // all-ones identity, seeding
    add_row(CMD_ROW, ones);                  // repeat within snapshot
    add_row(CMD_UNUSED, ones);               // unused command code
    add_row(CMD_END, '0, 1, done_ev);
    add_row(CMD_ROW, ones);                  // survivor, no event
    add_row(CMD_ROW, pool_ident(1));         // created
    add_row(CMD_END, '0);                    // all-zero identity closed
    add_row(CMD_END, '0);                    // both vanish
    add_row(CMD_END, '0, 1, done_ev);        // nothing left
    add_row(CMD_ROW, pool_ident(2));
    add_row(CMD_CLEAR, '0);                  // restarts seeding
    add_row(CMD_ROW, pool_ident(3));         // seeding again, no event
    add_row(CMD_END, '0, 1, done_ev);

    foreach (directed[i]) begin
      if (directed[i].typed) begin
        wait_drained();
        send_item(directed[i].command, directed[i].ident);
        if (pending_events.size() != 1 || pending_events[0] != directed[i].typed_event) begin
          $display("%0t: directed row %0d expected %h actual prediction differs",
                   $time, i, directed[i].typed_event);
          failures++;
        end
      end else begin
        send_item(directed[i].command, directed[i].ident);
      end
    end
    wait_drained();

    // Table overflow: fill every slot, then one more row is dropped.
    send_item(CMD_CLEAR, '0);
    for (int i = 0; i < TABLE_DEPTH; i++) send_item(CMD_ROW, random_ident());
    full_ev.kind  = KIND_FULL;
    full_ev.ident = random_ident();
    full_ev.last  = 1'b1;
    wait_drained();
    send_item(CMD_ROW, full_ev.ident);
    if (pending_events.size() != 1 || pending_events[0] != full_ev) begin
      $display("%0t: overflow expected %h actual prediction differs", $time, full_ev);
      failures++;
    end
    send_item(CMD_END, '0);
    send_item(CMD_END, '0);                  // all 64 close together

    // Random snapshots over a small pool, with some noise, across idling phases.
    live_pool = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int n = 0; n < 22; n++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
          send_item(CMD_END, '0);
        end else if (pick < 14) begin
          send_item(CMD_CLEAR, random_ident());
        end else if (pick < 15) begin
          send_item(CMD_UNUSED, random_ident());
        end else if (pick < 25) begin
          send_item(CMD_ROW, random_ident());
        end else begin
          send_item(CMD_ROW, pool_ident($urandom_range(23)));
        end
      end
      send_item(CMD_END, '0);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (300) @(posedge clk);
    if (cycle_count >= RUN_LIMIT) begin
      $display("connection_snapshot_diff verification failed");
    end else if (failures == 0 && pending_events.size() == 0) begin
      $display("connection_snapshot_diff verification clean");
    end else begin
      $display("connection_snapshot_diff verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    if (cycle_count >= RUN_LIMIT + 400) begin
      $display("connection_snapshot_diff verification failed");
      $finish;
    end
  end

endmodule
`default_nettype wire

### connection_snapshot_diff.f
rtl/csd_pkg.sv
rtl/csd_front.sv
rtl/csd_fifo.sv
rtl/csd_back.sv
rtl/connection_snapshot_diff.sv
tb/connection_snapshot_diff_test.sv
